// ===== hw/rtl/fdf_pkg.sv =====
package fdf_pkg;

    localparam int DUP_ENTRIES = 16;
    localparam int IDX_W       = (DUP_ENTRIES > 1) ? $clog2(DUP_ENTRIES) : 1;
    localparam int LEAVES      = 1 << IDX_W;
    localparam int LEVELS      = IDX_W;
    localparam int SETTLE_W    = $clog2(LEVELS + 1);
    localparam int CNT_W       = $clog2(DUP_ENTRIES + 1);

    localparam int ADDR_W      = 8;
    localparam int SEQ_W       = 8;
    localparam int TTL_W       = 8;
    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 16;
    localparam int VERDICT_W   = 3;
    localparam int OUT_CNT_W   = 5;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_HOLD    = 1'd1;

    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 8'd1;
    localparam logic [HOLD_W-1:0] DUP_HOLD_RST    = 16'd30;
    localparam logic [ADDR_W-1:0] SENDER_UNKNOWN  = 8'd0;
    localparam logic [TTL_W-1:0]  TTL_ZERO        = 8'd0;
    localparam logic [TTL_W-1:0]  TTL_ONE         = 8'd1;

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_SWEEP   = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [VERDICT_W-1:0] {
        V_NEW      = 3'd0,
        V_DUP      = 3'd1,
        V_TTL_ZERO = 3'd2,
        V_OWN      = 3'd3,
        V_UNKNOWN  = 3'd4,
        V_SWEEP    = 3'd5
    } t_verdict;

    // classified request handed from front to back
    typedef struct packed {
        t_verdict          verdict;
        logic [ADDR_W-1:0] origin_id;
        logic [SEQ_W-1:0]  seq_number;
        logic [ADDR_W-1:0] sender_id;
        logic [TIME_W-1:0] now;
        logic              fwd_ok;
    } t_req;

endpackage

// ===== hw/rtl/fdf_in_if.sv =====
interface fdf_in_if import fdf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] origin_id;
    logic [SEQ_W-1:0]  seq_number;
    logic [ADDR_W-1:0] sender_id;
    logic [TTL_W-1:0]  ttl;
    logic [TIME_W-1:0] now;
    logic              mpr_selector_present;

    modport source (
        output valid, operation, origin_id, seq_number, sender_id, ttl, now,
               mpr_selector_present,
        input  ready
    );
    modport sink (
        input  valid, operation, origin_id, seq_number, sender_id, ttl, now,
               mpr_selector_present,
        output ready
    );
endinterface

// ===== hw/rtl/fdf_out_if.sv =====
interface fdf_out_if import fdf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 forward;
    logic                 first_seen;
    logic [VERDICT_W-1:0] verdict;
    logic [OUT_CNT_W-1:0] entries_in_use;

    modport source (
        output valid, forward, first_seen, verdict, entries_in_use,
        input  ready
    );
    modport sink (
        input  valid, forward, first_seen, verdict, entries_in_use,
        output ready
    );
endinterface

// ===== hw/rtl/flood_duplicate_filter.sv =====
// flooded-message duplicate filter
//
// i_msg carries one request per item: a message arrival (origin, sequence,
// sender, ttl, time, relay-selected flag) or an expiry sweep at a given time.
// o_res returns exactly one result per request, in order: forward flag,
// first-seen flag, verdict and the number of table entries in use afterwards.
// own address and hold time are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must do so while the block is idle, it is not enforced.
//
// a request enters a two-deep queue, then the table engine moves from idle to
// lookup and, for a dropped message, straight to emit; a sweep passes through
// the sweep state and a table message through the update state before emit.
// when a full table must replace its oldest entry before the registered
// expiry compare tree has settled after the previous write, the engine waits.
// reset empties the table and loads own address 1, hold time 30.
// a stalled receiver holds the result in the output register; the queue keeps
// taking requests until it fills, then i_msg.ready drops.
module flood_duplicate_filter import fdf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fdf_in_if.sink                i_msg,
    fdf_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ADDR_W-1:0] r_own_address;
    logic [HOLD_W-1:0] r_dup_hold;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_req q_in;
    t_req q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDRESS_RST;
            r_dup_hold    <= DUP_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_ADDRESS: r_own_address <= i_cfg_data[ADDR_W-1:0];
                CFG_DUP_HOLD:    r_dup_hold    <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    fdf_front u_front (
        .i_msg         (i_msg),
        .i_own_address (r_own_address),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_req         (q_in)
    );

    fdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_out)
    );

    fdf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (r_dup_hold),
        .i_q_valid (q_valid),
        .i_q_req   (q_out),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== hw/rtl/fdf_front.sv =====
module fdf_front import fdf_pkg::*; (
    fdf_in_if.sink            i_msg,
    input  logic [ADDR_W-1:0] i_own_address,
    input  logic              i_full,
    output logic              o_push,
    output t_req              o_req
);

    assign i_msg.ready = !i_full;
    assign o_push      = i_msg.valid && !i_full;

    // drop checks in priority order, sweep bypasses them
    always_comb begin
        o_req.origin_id  = i_msg.origin_id;
        o_req.seq_number = i_msg.seq_number;
        o_req.sender_id  = i_msg.sender_id;
        o_req.now        = i_msg.now;
        o_req.fwd_ok     = (i_msg.ttl > TTL_ONE) && i_msg.mpr_selector_present;
        priority if (i_msg.operation == OP_SWEEP) begin
            o_req.verdict = V_SWEEP;
        end else if (i_msg.ttl == TTL_ZERO) begin
            o_req.verdict = V_TTL_ZERO;
        end else if (i_msg.origin_id == i_own_address) begin
            o_req.verdict = V_OWN;
        end else if (i_msg.sender_id == SENDER_UNKNOWN) begin
            o_req.verdict = V_UNKNOWN;
        end else begin
            o_req.verdict = V_NEW;
        end
    end

endmodule

// ===== hw/rtl/fdf_queue.sv =====
module fdf_queue import fdf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_req
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("request popped from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

// ===== hw/rtl/fdf_back.sv =====
module fdf_back import fdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [HOLD_W-1:0] i_hold,
    input  logic              i_q_valid,
    input  t_req              i_q_req,
    output logic              o_q_pop,
    fdf_out_if.source         o_res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_UPD   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic              ok;
        logic [TIME_W-1:0] expiry;
        logic [IDX_W-1:0]  idx;
    } t_node;

    function automatic t_node f_pick(t_node a, t_node b);
        t_node r;
        r = a;
        if (b.ok && (!a.ok || b.expiry < a.expiry)) begin
            r = b;
        end
        return r;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [DUP_ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]      r_origin [DUP_ENTRIES];
    logic [SEQ_W-1:0]       r_seq    [DUP_ENTRIES];
    logic [ADDR_W-1:0]      r_sender [DUP_ENTRIES];
    logic                   r_retx   [DUP_ENTRIES];
    logic [TIME_W-1:0]      r_expiry [DUP_ENTRIES];
    logic [CNT_W-1:0]       r_count;
    logic [SETTLE_W-1:0]    r_settle;

    t_req                   r_req;
    logic                   r_found;
    logic [IDX_W-1:0]       r_hit_idx;
    logic                   r_cand;
    logic                   r_free_any;
    logic [IDX_W-1:0]       r_free_idx;
    logic [DUP_ENTRIES-1:0] r_mask;
    logic                   r_fwd;
    t_verdict               r_verdict;

    logic                   r_out_valid;
    logic                   r_out_fwd;
    logic                   r_out_first;
    t_verdict               r_out_verdict;
    logic [OUT_CNT_W-1:0]   r_out_count;

    logic                   w_hit;
    logic [IDX_W-1:0]       w_hit_idx;
    logic                   w_hit_cand;
    logic                   w_free_any;
    logic [IDX_W-1:0]       w_free_idx;
    logic [DUP_ENTRIES-1:0] w_mask;
    logic                   w_wait;
    logic                   w_write;
    logic [IDX_W-1:0]       w_slot;
    logic                   w_out_load;

    t_node w_leaf [LEAVES];
    t_node r_tree [LEVELS][LEAVES/2];

    // oldest-entry search: registered compare tree over the expiry times
    genvar g, l, k;
    for (g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < DUP_ENTRIES) begin : g_real
            assign w_leaf[g] = '{ok: 1'b1, expiry: r_expiry[g], idx: IDX_W'(g)};
        end else begin : g_pad
            assign w_leaf[g] = '{ok: 1'b0, expiry: '0, idx: IDX_W'(g)};
        end
    end

    for (l = 0; l < LEVELS; l++) begin : g_lvl
        for (k = 0; k < (LEAVES >> (l + 1)); k++) begin : g_node
            if (l == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_tree[0][k] <= f_pick(w_leaf[2*k], w_leaf[2*k+1]);
                end
            end else begin : g_upper
                always_ff @(posedge i_clk) begin
                    r_tree[l][k] <= f_pick(r_tree[l-1][2*k], r_tree[l-1][2*k+1]);
                end
            end
        end
    end

    // match, first free slot and expired mask, lowest index wins
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_hit_cand = 1'b0;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = DUP_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_origin[i] == r_req.origin_id &&
                r_seq[i] == r_req.seq_number) begin
                w_hit      = 1'b1;
                w_hit_idx  = IDX_W'(i);
                w_hit_cand = !r_retx[i] && (r_sender[i] != r_req.sender_id);
            end
            if (!r_valid[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IDX_W'(i);
            end
            w_mask[i] = r_valid[i] && (r_expiry[i] < r_req.now);
        end
    end

    // replacement waits until the tree reflects the last table write
    assign w_wait  = r_cand && !r_found && !r_free_any && (r_settle != '0);
    assign w_write = (r_state == S_UPD) && r_cand && !w_wait;

    always_comb begin
        priority if (r_found) begin
            w_slot = r_hit_idx;
        end else if (r_free_any) begin
            w_slot = r_free_idx;
        end else begin
            w_slot = r_tree[LEVELS-1][0].idx;
        end
    end

    assign w_out_load = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                priority if (r_req.verdict == V_SWEEP) begin
                    n_state = S_SWEEP;
                end else if (r_req.verdict == V_NEW) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SWEEP: n_state = S_EMIT;
            S_UPD: begin
                if (!w_wait) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_settle    <= SETTLE_W'(LEVELS);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_valid <= r_valid & ~r_mask;
                r_count <= r_count - CNT_W'($countones(r_mask));
            end else if (w_write && !r_valid[w_slot]) begin
                r_valid[w_slot] <= 1'b1;
                r_count         <= r_count + 1'b1;
            end
            if (w_write) begin
                r_settle <= SETTLE_W'(LEVELS);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_req;
        end
        if (r_state == S_LOOK) begin
            r_found    <= w_hit;
            r_hit_idx  <= w_hit_idx;
            r_cand     <= w_hit ? w_hit_cand : 1'b1;
            r_free_any <= w_free_any;
            r_free_idx <= w_free_idx;
            r_mask     <= w_mask;
            if (r_req.verdict == V_NEW) begin
                r_verdict <= w_hit ? V_DUP : V_NEW;
                r_fwd     <= (w_hit ? w_hit_cand : 1'b1) && r_req.fwd_ok;
            end else begin
                r_verdict <= r_req.verdict;
                r_fwd     <= 1'b0;
            end
        end
        if (w_write) begin
            r_expiry[w_slot] <= r_req.now + TIME_W'(i_hold);
            r_retx[w_slot]   <= r_fwd;
            r_sender[w_slot] <= r_req.sender_id;
            if (!r_found) begin
                r_origin[w_slot] <= r_req.origin_id;
                r_seq[w_slot]    <= r_req.seq_number;
            end
        end
        if (w_out_load) begin
            r_out_fwd     <= r_fwd;
            r_out_first   <= (r_verdict == V_NEW);
            r_out_verdict <= r_verdict;
            r_out_count   <= OUT_CNT_W'(r_count);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.forward        = r_out_fwd;
    assign o_res.first_seen     = r_out_first;
    assign o_res.verdict        = r_out_verdict;
    assign o_res.entries_in_use = r_out_count;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("entry count differs from valid bits");

    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> r_valid[$past(w_slot)])
        else $error("written entry not marked valid");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside emit state");

endmodule

// ===== dv/tb_flood_duplicate_filter.sv =====
`timescale 1ns / 1ps

module tb_flood_duplicate_filter;
    import fdf_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int PHASE_MESSAGES = 194;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] origin;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] sender;
        logic [TTL_W-1:0]  ttl;
        logic [TIME_W-1:0] now;
        logic              mpr;
    } msg_item_t;

    typedef struct packed {
        logic                 fwd;
        logic                 first;
        t_verdict             verdict;
        logic [OUT_CNT_W-1:0] in_use;
    } filter_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fdf_in_if  msg_if ();
    fdf_out_if res_if ();

    flood_duplicate_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_msg      (msg_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the duplicate table
    logic              dup_valid  [DUP_ENTRIES];
    logic [ADDR_W-1:0] dup_origin [DUP_ENTRIES];
    logic [SEQ_W-1:0]  dup_seq    [DUP_ENTRIES];
    logic [ADDR_W-1:0] dup_sender [DUP_ENTRIES];
    logic              dup_rexmit [DUP_ENTRIES];
    logic [TIME_W-1:0] dup_expiry [DUP_ENTRIES];
    int                dup_count;

    logic [ADDR_W-1:0] own_addr;
    logic [HOLD_W-1:0] hold_time;
    logic [TIME_W-1:0] clock_now;

    msg_item_t      pending_msgs[$];
    filter_result_t predicted_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned fail_count;
    int unsigned stall_cycles;
    logic        msg_taken;

    function automatic msg_item_t make_msg(logic op, logic [ADDR_W-1:0] origin,
                                           logic [SEQ_W-1:0] seq,
                                           logic [ADDR_W-1:0] sender,
                                           logic [TTL_W-1:0] ttl,
                                           logic [TIME_W-1:0] now, logic mpr);
        msg_item_t m;
        m.op     = op;
        m.origin = origin;
        m.seq    = seq;
        m.sender = sender;
        m.ttl    = ttl;
        m.now    = now;
        m.mpr    = mpr;
        return m;
    endfunction

    function automatic filter_result_t classify_message(msg_item_t m);
        filter_result_t r;
        int             slot;
        logic           found;
        logic           cand;
        r.fwd   = 1'b0;
        r.first = 1'b0;
        slot    = 0;
        found   = 1'b0;
        if (m.op == OP_SWEEP) begin
            r.verdict = V_SWEEP;
            for (int i = 0; i < DUP_ENTRIES; i++) begin
                if (dup_valid[i] && dup_expiry[i] < m.now) begin
                    dup_valid[i] = 1'b0;
                    dup_count--;
                end
            end
        end else if (m.ttl == TTL_ZERO) begin
            r.verdict = V_TTL_ZERO;
        end else if (m.origin == own_addr) begin
            r.verdict = V_OWN;
        end else if (m.sender == SENDER_UNKNOWN) begin
            r.verdict = V_UNKNOWN;
        end else begin
            // walk downward so the lowest matching slot wins
            for (int i = DUP_ENTRIES - 1; i >= 0; i--) begin
                if (dup_valid[i] && dup_origin[i] == m.origin && dup_seq[i] == m.seq) begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            cand = !found || (!dup_rexmit[slot] && dup_sender[slot] != m.sender);
            if (cand) begin
                r.fwd = (m.ttl > TTL_ONE) && m.mpr;
                if (!found) begin
                    slot = -1;
                    for (int i = DUP_ENTRIES - 1; i >= 0; i--) begin
                        if (!dup_valid[i])
                            slot = i;
                    end
                    if (slot < 0) begin
                        // full: evict earliest expiry, lowest slot on a tie
                        slot = 0;
                        for (int i = 1; i < DUP_ENTRIES; i++) begin
                            if (dup_expiry[i] < dup_expiry[slot])
                                slot = i;
                        end
                    end else begin
                        dup_valid[slot] = 1'b1;
                        dup_count++;
                    end
                    dup_origin[slot] = m.origin;
                    dup_seq[slot]    = m.seq;
                end
                dup_expiry[slot] = m.now + TIME_W'(hold_time);
                dup_rexmit[slot] = r.fwd;
                dup_sender[slot] = m.sender;
            end
            r.first   = !found;
            r.verdict = found ? V_DUP : V_NEW;
        end
        r.in_use = OUT_CNT_W'(dup_count);
        return r;
    endfunction

    // small origin and sequence pools keep duplicates and evictions frequent
    function automatic msg_item_t random_message();
        msg_item_t   m;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            clock_now = $urandom();
        else
            clock_now = clock_now + $urandom_range(0, hold_time / 6 + 1);
        m.op     = OP_MESSAGE;
        m.now    = clock_now;
        m.mpr    = 1'($urandom_range(0, 1));
        m.origin = ADDR_W'($urandom_range(0, 7));
        m.seq    = SEQ_W'($urandom_range(0, 3));
        m.sender = ADDR_W'($urandom_range(1, 4));
        m.ttl    = TTL_W'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0)
            m.origin = ADDR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            m.seq = SEQ_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            m.sender = ADDR_W'($urandom_range(1, 255));
        if ($urandom_range(0, 9) == 0)
            m.ttl = TTL_W'($urandom_range(1, 255));
        if (pick < 8) begin
            m.op     = OP_SWEEP;
            m.origin = ADDR_W'($urandom_range(0, 255));
            m.seq    = SEQ_W'($urandom_range(0, 255));
            m.sender = ADDR_W'($urandom_range(0, 255));
            m.ttl    = TTL_W'($urandom_range(0, 255));
        end else if (pick < 10) begin
            m.ttl = TTL_ZERO;
        end else if (pick < 12) begin
            m.origin = own_addr;
        end else if (pick < 14) begin
            m.sender = SENDER_UNKNOWN;
        end
        return m;
    endfunction

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OWN_ADDRESS)
            own_addr = data[ADDR_W-1:0];
        else
            hold_time = data;
    endtask

    task automatic wait_drained();
        while (pending_msgs.size() != 0 || msg_if.valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(negedge i_clk) begin
        msg_item_t m;
        if (i_rst_n && (!msg_if.valid || msg_taken)) begin
            if (pending_msgs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                m = pending_msgs.pop_front();
                msg_if.valid                <= 1'b1;
                msg_if.operation            <= m.op;
                msg_if.origin_id            <= m.origin;
                msg_if.seq_number           <= m.seq;
                msg_if.sender_id            <= m.sender;
                msg_if.ttl                  <= m.ttl;
                msg_if.now                  <= m.now;
                msg_if.mpr_selector_present <= m.mpr;
            end else begin
                msg_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        filter_result_t want;
        msg_taken <= msg_if.valid && msg_if.ready;
        if (i_rst_n && msg_if.valid && msg_if.ready) begin
            predicted_results.push_back(classify_message(make_msg(
                msg_if.operation, msg_if.origin_id, msg_if.seq_number, msg_if.sender_id,
                msg_if.ttl, msg_if.now, msg_if.mpr_selector_present)));
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (predicted_results.size() == 0) begin
                $error("unexpected result: verdict %0d", res_if.verdict);
                fail_count++;
            end else begin
                want = predicted_results.pop_front();
                if (res_if.forward !== want.fwd) begin
                    $error("forward: expected %0d, got %0d", want.fwd, res_if.forward);
                    fail_count++;
                end
                if (res_if.first_seen !== want.first) begin
                    $error("first_seen: expected %0d, got %0d", want.first, res_if.first_seen);
                    fail_count++;
                end
                if (res_if.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, res_if.verdict);
                    fail_count++;
                end
                if (res_if.entries_in_use !== want.in_use) begin
                    $error("entries_in_use: expected %0d, got %0d",
                           want.in_use, res_if.entries_in_use);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("flood_duplicate_filter regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n                     = 1'b0;
        i_cfg_we                    = 1'b0;
        i_cfg_idx                   = '0;
        i_cfg_data                  = '0;
        msg_if.valid                = 1'b0;
        msg_if.operation            = OP_MESSAGE;
        msg_if.origin_id            = '0;
        msg_if.seq_number           = '0;
        msg_if.sender_id            = '0;
        msg_if.ttl                  = '0;
        msg_if.now                  = '0;
        msg_if.mpr_selector_present = 1'b0;
        res_if.ready                = 1'b0;
        msg_taken                   = 1'b0;
        stall_cycles                = 0;
        fail_count                  = 0;
        send_idle_pct               = 0;
        recv_stall_pct              = 0;
        own_addr                    = OWN_ADDRESS_RST;
        hold_time                   = DUP_HOLD_RST;
        clock_now                   = '0;
        dup_count                   = 0;
        for (int i = 0; i < DUP_ENTRIES; i++) begin
            dup_valid[i]  = 1'b0;
            dup_origin[i] = '0;
            dup_seq[i]    = '0;
            dup_sender[i] = '0;
            dup_rexmit[i] = 1'b0;
            dup_expiry[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drop reasons, checked in priority order
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd1, 8'd0, 8'd0, TTL_ZERO, 32'd100, 1'b1));
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd1, 8'd0, 8'd0, 8'd5, 32'd100, 1'b1));
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd9, 8'd0, 8'd0, 8'd5, 32'd100, 1'b1));
        // zero origin is a normal address; second copy is already retransmitted
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd0, 8'd0, 8'd2, 8'd2, 32'd100, 1'b1));
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd0, 8'd0, 8'd3, 8'd2, 32'd100, 1'b1));
        // ttl one never forwards; same sender is no candidate; new sender refreshes
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd5, 8'd7, 8'd2, TTL_ONE, 32'd100, 1'b1));
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd5, 8'd7, 8'd2, 8'd9, 32'd100, 1'b1));
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd5, 8'd7, 8'd4, 8'd255, 32'd100, 1'b1));
        pending_msgs.push_back(make_msg(OP_MESSAGE, 8'd255, 8'd255, 8'd255, 8'd255,
                                        32'd100, 1'b0));
        // fill past capacity: evictions hit the tied oldest entries
        for (int i = 0; i < 15; i++) begin
            pending_msgs.push_back(make_msg(OP_MESSAGE, 8'(10 + i), 8'(i), 8'(1 + i), 8'd2,
                                            32'(200 + i / 4), 1'(i)));
        end
        pending_msgs.push_back(make_msg(OP_SWEEP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0, 1'b1));
        pending_msgs.push_back(make_msg(OP_SWEEP, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0));
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase / 2)
                0: begin
                    write_config(CFG_OWN_ADDRESS, 16'd255);
                    write_config(CFG_DUP_HOLD, 16'd1);
                end
                1: begin
                    write_config(CFG_OWN_ADDRESS, 16'd1);
                    write_config(CFG_DUP_HOLD, 16'd65535);
                end
                2: begin
                    write_config(CFG_OWN_ADDRESS, CFG_DATA_W'($urandom_range(1, 255)));
                    write_config(CFG_DUP_HOLD, CFG_DATA_W'($urandom_range(1, 200)));
                end
                default: begin
                    write_config(CFG_OWN_ADDRESS, 16'd128);
                    write_config(CFG_DUP_HOLD, 16'd30);
                end
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            for (int n = 0; n < PHASE_MESSAGES; n++)
                pending_msgs.push_back(random_message());
            wait_drained();
        end

        if (fail_count == 0)
            $display("flood_duplicate_filter regression: pass");
        else
            $display("flood_duplicate_filter regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fdf_pkg.sv
hw/rtl/fdf_in_if.sv
hw/rtl/fdf_out_if.sv
hw/rtl/fdf_front.sv
hw/rtl/fdf_queue.sv
hw/rtl/fdf_back.sv
hw/rtl/flood_duplicate_filter.sv
dv/tb_flood_duplicate_filter.sv
